### design/bspq_pkg.sv
// Shared types and constants for the BSP extremal vertex query block.
// Used by the top level; holds the node table layout and the item packing.
// No dependencies.
package bspq_pkg;

	// Table and field sizes.
	localparam int NODE_COUNT = 256;
	localparam int NODE_BITS  = $clog2(NODE_COUNT);
	localparam int VISIT_BITS = $clog2(NODE_COUNT + 1);
	localparam int COMP_BITS  = 16;
	localparam int CHILD_BITS = 9;
	localparam int VERT_BITS  = 8;
	localparam int INDEX_BITS = 8;
	localparam int PROD_BITS  = 2 * COMP_BITS;
	localparam int ACC_BITS   = PROD_BITS + 2;

	// Request kinds carried in s_tuser.
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	// One stored node normal.
	typedef struct packed {
		logic signed [COMP_BITS-1:0] z;
		logic signed [COMP_BITS-1:0] y;
		logic signed [COMP_BITS-1:0] x;
	} normal_t;

	// One stored node's children and leaf vertices.
	typedef struct packed {
		logic signed [CHILD_BITS-1:0] pos_child;
		logic signed [CHILD_BITS-1:0] neg_child;
		logic [VERT_BITS-1:0]         pos_vertex;
		logic [VERT_BITS-1:0]         neg_vertex;
	} link_t;

	localparam int IN_FIELD_BITS = INDEX_BITS + 6 * COMP_BITS + 2 * CHILD_BITS
		+ 2 * VERT_BITS;
	localparam int IN_DATA_BITS = ((IN_FIELD_BITS + 7) / 8) * 8;
	localparam int IN_PAD_BITS = IN_DATA_BITS - IN_FIELD_BITS;

	// Input request payload, first member is the most significant.
	typedef struct packed {
		logic [IN_PAD_BITS-1:0]       pad;
		logic signed [COMP_BITS-1:0]  dir_z;
		logic signed [COMP_BITS-1:0]  dir_y;
		logic signed [COMP_BITS-1:0]  dir_x;
		logic [VERT_BITS-1:0]         neg_vertex;
		logic [VERT_BITS-1:0]         pos_vertex;
		logic signed [CHILD_BITS-1:0] neg_child;
		logic signed [CHILD_BITS-1:0] pos_child;
		logic signed [COMP_BITS-1:0]  normal_z;
		logic signed [COMP_BITS-1:0]  normal_y;
		logic signed [COMP_BITS-1:0]  normal_x;
		logic [INDEX_BITS-1:0]        node_index;
	} in_data_t;

	localparam int OUT_DATA_BITS = 2 * VERT_BITS;

endpackage

### design/bspq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the node normal and node link tables; no dependencies.
module bspq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

### design/bsp_extremal_vertex_query_top.sv
// A write request (s_tuser = 0) stores one BSP node and gives no result. A query
// request (s_tuser = 1) walks the tree twice from node 0 and returns the vertex extreme along
// the direction and the one extreme along its opposite; walk_error is set, and that walk's
// vertex reads 0, when a walk reaches a child slot beyond the table or visits every node without
// reaching a leaf. Each visited node passes through S_READ for the registered table read, then
// S_MUL_X, S_MUL_Y and S_MUL_Z, in which the single shared 16x16 multiplier forms the three
// products of the dot product one after another, and S_DECIDE, where the sign decides the
// branch. Slots read before they are written return arbitrary data.
//
// Top level; depends on bspq_pkg and bspq_ram.
module bsp_extremal_vertex_query_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// node_index, normal_x, normal_y, normal_z, pos_child, neg_child, pos_vertex,
	// neg_vertex, dir_x, dir_y, dir_z, zero pad (lowest bit up)
	input  logic [bspq_pkg::IN_DATA_BITS-1:0]    s_tdata,
	// action
	input  logic [0:0]                           s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// max_vertex, min_vertex (lowest bit up)
	output logic [bspq_pkg::OUT_DATA_BITS-1:0]   m_tdata,
	// walk_error
	output logic [0:0]                           m_tuser
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_MUL_X,
		S_MUL_Y,
		S_MUL_Z,
		S_DECIDE,
		S_DONE
	} state_t;

	state_t                                  state_q;
	bspq_pkg::in_data_t                      req;
	logic                                    req_fire;
	logic                                    wr_en;
	bspq_pkg::normal_t                       norm_wr;
	bspq_pkg::normal_t                       norm_rd;
	bspq_pkg::link_t                         link_wr;
	bspq_pkg::link_t                         link_rd;
	logic [bspq_pkg::NODE_BITS-1:0]          cur_q;
	logic [bspq_pkg::VISIT_BITS-1:0]         visits_q;
	logic                                    flip_q;
	logic signed [bspq_pkg::COMP_BITS-1:0]   dir_x_q;
	logic signed [bspq_pkg::COMP_BITS-1:0]   dir_y_q;
	logic signed [bspq_pkg::COMP_BITS-1:0]   dir_z_q;
	logic signed [bspq_pkg::COMP_BITS-1:0]   op_a;
	logic signed [bspq_pkg::COMP_BITS-1:0]   op_b;
	logic signed [bspq_pkg::PROD_BITS-1:0]   prod;
	logic signed [bspq_pkg::PROD_BITS-1:0]   prod_q;
	logic signed [bspq_pkg::ACC_BITS-1:0]    acc_q;
	logic signed [bspq_pkg::ACC_BITS-1:0]    dot_sum;
	logic                                    dot_neg;
	logic                                    dot_zero;
	logic                                    go_pos;
	logic signed [bspq_pkg::CHILD_BITS-1:0]  nxt;
	logic [bspq_pkg::VERT_BITS-1:0]          leaf_vertex;
	logic [bspq_pkg::VISIT_BITS-1:0]         visits_nxt;
	logic                                    walk_fail;
	logic [bspq_pkg::VERT_BITS-1:0]          max_q;
	logic [bspq_pkg::VERT_BITS-1:0]          min_q;
	logic                                    err_q;
	logic [bspq_pkg::VERT_BITS-1:0]          out_max_q;
	logic [bspq_pkg::VERT_BITS-1:0]          out_min_q;
	logic                                    out_err_q;
	logic                                    out_load;

	assign req      = bspq_pkg::in_data_t'(s_tdata);
	assign s_tready = (state_q == S_IDLE);
	assign req_fire = s_tvalid && s_tready;

	// Node writes; slots beyond the table are dropped.
	assign wr_en = req_fire && (s_tuser[0] == bspq_pkg::ACT_WRITE)
		&& (int'(req.node_index) < bspq_pkg::NODE_COUNT);
	assign norm_wr = '{z: req.normal_z, y: req.normal_y, x: req.normal_x};
	assign link_wr = '{pos_child: req.pos_child, neg_child: req.neg_child,
		pos_vertex: req.pos_vertex, neg_vertex: req.neg_vertex};

	bspq_ram #(
		.WIDTH($bits(bspq_pkg::normal_t)),
		.DEPTH(bspq_pkg::NODE_COUNT)
	) u_normals (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (req.node_index[bspq_pkg::NODE_BITS-1:0]),
		.wr_data (norm_wr),
		.rd_addr (cur_q),
		.rd_data (norm_rd)
	);

	bspq_ram #(
		.WIDTH($bits(bspq_pkg::link_t)),
		.DEPTH(bspq_pkg::NODE_COUNT)
	) u_links (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (req.node_index[bspq_pkg::NODE_BITS-1:0]),
		.wr_data (link_wr),
		.rd_addr (cur_q),
		.rd_data (link_rd)
	);

	// Shared multiplier: the sequencer steps it through the three components.
	always_comb begin
		case (state_q)
			S_MUL_Y: begin
				op_a = norm_rd.y;
				op_b = dir_y_q;
			end
			S_MUL_Z: begin
				op_a = norm_rd.z;
				op_b = dir_z_q;
			end
			default: begin
				op_a = norm_rd.x;
				op_b = dir_x_q;
			end
		endcase
	end
	assign prod = op_a * op_b;

	// Final sum and sign of the dot product, then the branch decision.
	assign dot_sum  = acc_q + bspq_pkg::ACC_BITS'(prod_q);
	assign dot_neg  = dot_sum[bspq_pkg::ACC_BITS-1];
	assign dot_zero = (dot_sum == '0);
	assign go_pos   = flip_q ? (dot_neg || dot_zero) : !dot_neg;
	assign nxt         = go_pos ? link_rd.pos_child : link_rd.neg_child;
	assign leaf_vertex = go_pos ? link_rd.pos_vertex : link_rd.neg_vertex;
	assign visits_nxt  = visits_q + bspq_pkg::VISIT_BITS'(1);
	assign walk_fail   = (int'(nxt[bspq_pkg::CHILD_BITS-2:0]) >= bspq_pkg::NODE_COUNT)
		|| (int'(visits_nxt) >= bspq_pkg::NODE_COUNT);

	// The finished query moves to the output register once it is free.
	assign out_load = (state_q == S_DONE) && (!m_tvalid || m_tready);

	// Sequencer, walk state and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			m_tvalid  <= 1'b0;
			cur_q     <= '0;
			visits_q  <= '0;
			flip_q    <= 1'b0;
			err_q     <= 1'b0;
			dir_x_q   <= '0;
			dir_y_q   <= '0;
			dir_z_q   <= '0;
			prod_q    <= '0;
			acc_q     <= '0;
			max_q     <= '0;
			min_q     <= '0;
			out_max_q <= '0;
			out_min_q <= '0;
			out_err_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_fire && (s_tuser[0] == bspq_pkg::ACT_QUERY)) begin
						dir_x_q  <= req.dir_x;
						dir_y_q  <= req.dir_y;
						dir_z_q  <= req.dir_z;
						cur_q    <= '0;
						visits_q <= '0;
						flip_q   <= 1'b0;
						err_q    <= 1'b0;
						state_q  <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_MUL_X;
				end
				S_MUL_X: begin
					prod_q  <= prod;
					acc_q   <= '0;
					state_q <= S_MUL_Y;
				end
				S_MUL_Y: begin
					prod_q  <= prod;
					acc_q   <= acc_q + bspq_pkg::ACC_BITS'(prod_q);
					state_q <= S_MUL_Z;
				end
				S_MUL_Z: begin
					prod_q  <= prod;
					acc_q   <= acc_q + bspq_pkg::ACC_BITS'(prod_q);
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (!nxt[bspq_pkg::CHILD_BITS-1] && !walk_fail) begin
						// Step down to the child.
						cur_q    <= nxt[bspq_pkg::NODE_BITS-1:0];
						visits_q <= visits_nxt;
						state_q  <= S_READ;
					end else begin
						// Walk ends at a leaf or fails.
						if (!nxt[bspq_pkg::CHILD_BITS-1]) begin
							err_q <= 1'b1;
						end
						if (!flip_q) begin
							max_q    <= nxt[bspq_pkg::CHILD_BITS-1] ? leaf_vertex : '0;
							flip_q   <= 1'b1;
							cur_q    <= '0;
							visits_q <= '0;
							state_q  <= S_READ;
						end else begin
							min_q   <= nxt[bspq_pkg::CHILD_BITS-1] ? leaf_vertex : '0;
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (out_load) begin
						out_max_q <= max_q;
						out_min_q <= min_q;
						out_err_q <= err_q;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tdata    = {out_min_q, out_max_q};
	assign m_tuser[0] = out_err_q;

	// A query request starts a walk at the root on the next cycle.
	a_query_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(req_fire && s_tuser[0] == bspq_pkg::ACT_QUERY)
		|=> (state_q == S_READ && cur_q == '0 && visits_q == '0 && !flip_q))
		else $error("query did not start at the root");

	// The visit count never passes the table size.
	a_visits_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(visits_q) < bspq_pkg::NODE_COUNT)
		else $error("visit count out of range");

	// A result appears only after the second walk has finished.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> ($past(state_q) == S_DONE && $past(flip_q)))
		else $error("result produced outside the done state");

	// A write request never produces a result.
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(req_fire && s_tuser[0] == bspq_pkg::ACT_WRITE)
		|=> (state_q == S_IDLE && !$rose(m_tvalid)))
		else $error("write request produced a result");

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the BSP extremal vertex query block: loads random node tables,
// runs direction queries under varied stream back-pressure and checks every result in order.
// Depends on bspq_pkg and bsp_extremal_vertex_query_top.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TOTAL_ITEMS  = 750;
	localparam int FILL_HOLD    = 500;
	localparam int DRAIN_CYCLES = 5 * 2 * bspq_pkg::NODE_COUNT + 50;

	// Idling patterns applied to the two stream sides.
	typedef enum int {CALM, LAZY_SENDER, SLOW_SINK, BOTH_SLOW} pace_t;

	// Shadow copy of one table slot.
	typedef struct {
		bit                                     loaded;
		logic signed [bspq_pkg::COMP_BITS-1:0]  nx;
		logic signed [bspq_pkg::COMP_BITS-1:0]  ny;
		logic signed [bspq_pkg::COMP_BITS-1:0]  nz;
		logic signed [bspq_pkg::CHILD_BITS-1:0] kid_pos;
		logic signed [bspq_pkg::CHILD_BITS-1:0] kid_neg;
		logic [bspq_pkg::VERT_BITS-1:0]         vtx_pos;
		logic [bspq_pkg::VERT_BITS-1:0]         vtx_neg;
	} slot_t;

	// Expected outcome of one query request.
	typedef struct {
		logic [bspq_pkg::VERT_BITS-1:0] max_vertex;
		logic [bspq_pkg::VERT_BITS-1:0] min_vertex;
		logic                           walk_error;
	} answer_t;

	// Keeps a shadow node table, predicts query answers and checks the returned ones.
	class vertex_query_board;
		slot_t   nodes[bspq_pkg::NODE_COUNT];
		answer_t answers[$];
		int      failures;

		function new();
			failures = 0;
		endfunction

		// Exact sign of the dot product of a node normal with the query direction.
		function int dot_sign(slot_t n, bspq_pkg::in_data_t q);
			longint acc;
			acc = longint'($signed(n.nx)) * longint'($signed(q.dir_x))
				+ longint'($signed(n.ny)) * longint'($signed(q.dir_y))
				+ longint'($signed(n.nz)) * longint'($signed(q.dir_z));
			if (acc > 0)
				return 1;
			if (acc < 0)
				return -1;
			return 0;
		endfunction

		// One descent from the root. The flipped descent takes the positive side when the
		// sign is zero or negative. A slot never loaded is reported through hole.
		function void descend(bspq_pkg::in_data_t q, bit flip, output bit ok,
				output logic [bspq_pkg::VERT_BITS-1:0] vertex, output int hole);
			int cur;
			int visits;
			int s;
			int nxt;
			bit go_pos;
			cur = 0;
			visits = 0;
			ok = 1'b0;
			vertex = '0;
			hole = -1;
			while (1'b1) begin
				if (!nodes[cur].loaded) begin
					hole = cur;
					return;
				end
				s = dot_sign(nodes[cur], q);
				go_pos = flip ? (s <= 0) : (s >= 0);
				nxt = go_pos ? int'(nodes[cur].kid_pos) : int'(nodes[cur].kid_neg);
				visits++;
				if (nxt < 0) begin
					ok = 1'b1;
					vertex = go_pos ? nodes[cur].vtx_pos : nodes[cur].vtx_neg;
					return;
				end
				// A child beyond the table or a walk that has seen every node fails.
				if (nxt >= bspq_pkg::NODE_COUNT || visits >= bspq_pkg::NODE_COUNT)
					return;
				cur = nxt;
			end
		endfunction

		// First never-loaded slot that either descent of this query would read, or -1.
		function int first_hole(bspq_pkg::in_data_t q);
			bit                             ok;
			logic [bspq_pkg::VERT_BITS-1:0] v;
			int                             hole;
			descend(q, 1'b0, ok, v, hole);
			if (hole >= 0)
				return hole;
			descend(q, 1'b1, ok, v, hole);
			return hole;
		endfunction

		// Account for an accepted request: a write updates the table, a query
		// queues its expected answer.
		function void note_request(logic [0:0] act, bspq_pkg::in_data_t d);
			bit                             ok_hi;
			bit                             ok_lo;
			logic [bspq_pkg::VERT_BITS-1:0] v_hi;
			logic [bspq_pkg::VERT_BITS-1:0] v_lo;
			int                             hole;
			answer_t                        a;
			if (act == bspq_pkg::ACT_WRITE) begin
				if (d.node_index < bspq_pkg::NODE_COUNT) begin
					nodes[d.node_index].loaded  = 1'b1;
					nodes[d.node_index].nx      = d.normal_x;
					nodes[d.node_index].ny      = d.normal_y;
					nodes[d.node_index].nz      = d.normal_z;
					nodes[d.node_index].kid_pos = d.pos_child;
					nodes[d.node_index].kid_neg = d.neg_child;
					nodes[d.node_index].vtx_pos = d.pos_vertex;
					nodes[d.node_index].vtx_neg = d.neg_vertex;
				end
			end else begin
				descend(d, 1'b0, ok_hi, v_hi, hole);
				descend(d, 1'b1, ok_lo, v_lo, hole);
				a.max_vertex = v_hi;
				a.min_vertex = v_lo;
				a.walk_error = !(ok_hi && ok_lo);
				answers = {answers, a};
			end
		endfunction

		// Compare one returned result with the oldest outstanding answer.
		function void check_result(logic [bspq_pkg::OUT_DATA_BITS-1:0] data, logic [0:0] flag);
			answer_t a;
			if (answers.size() == 0) begin
				failures++;
				$display("%0t ns: unexpected result max %0d min %0d error %0b",
					$time, data[bspq_pkg::VERT_BITS-1:0],
					data[2*bspq_pkg::VERT_BITS-1:bspq_pkg::VERT_BITS], flag);
				return;
			end
			a = answers.pop_front();
			if (data[bspq_pkg::VERT_BITS-1:0] !== a.max_vertex
					|| data[2*bspq_pkg::VERT_BITS-1:bspq_pkg::VERT_BITS] !== a.min_vertex
					|| flag !== a.walk_error) begin
				failures++;
				$display("%0t ns: expected max %0d min %0d error %0b, got max %0d min %0d error %0b",
					$time, a.max_vertex, a.min_vertex, a.walk_error,
					data[bspq_pkg::VERT_BITS-1:0],
					data[2*bspq_pkg::VERT_BITS-1:bspq_pkg::VERT_BITS], flag);
			end
		endfunction
	endclass

	logic                               clk = 1'b0;
	logic                               arst_n;
	logic                               s_tvalid;
	logic                               s_tready;
	logic [bspq_pkg::IN_DATA_BITS-1:0]  s_tdata;
	logic [0:0]                         s_tuser;
	logic                               m_tvalid;
	logic                               m_tready;
	logic [bspq_pkg::OUT_DATA_BITS-1:0] m_tdata;
	logic [0:0]                         m_tuser;

	vertex_query_board tally = new();
	pace_t pace       = CALM;
	bit    rushing    = 1'b0;
	int    hold_left  = 0;
	int    items_sent = 0;
	int    slot_map[bspq_pkg::NODE_COUNT];

	bsp_extremal_vertex_query_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// 100 MHz clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Component values weighted toward zero, the extremes and tiny magnitudes.
	function automatic logic [bspq_pkg::COMP_BITS-1:0] pick_comp();
		int r;
		r = $urandom_range(99);
		if (r < 15)
			return '0;
		if (r < 22)
			return 16'h8000;
		if (r < 29)
			return 16'h7FFF;
		if (r < 37)
			return bspq_pkg::COMP_BITS'($urandom_range(2, 0) - 1);
		return bspq_pkg::COMP_BITS'($urandom());
	endfunction

	// Any negative child link, all of which mark a leaf.
	function automatic logic [bspq_pkg::CHILD_BITS-1:0] leaf_link();
		return bspq_pkg::CHILD_BITS'($urandom_range((1 << bspq_pkg::CHILD_BITS) - 1,
			1 << (bspq_pkg::CHILD_BITS - 1)));
	endfunction

	// A request with every field random; callers override what matters.
	function automatic bspq_pkg::in_data_t noise();
		bspq_pkg::in_data_t d;
		d = '0;
		d.node_index = bspq_pkg::INDEX_BITS'($urandom());
		d.normal_x   = pick_comp();
		d.normal_y   = pick_comp();
		d.normal_z   = pick_comp();
		d.pos_child  = bspq_pkg::CHILD_BITS'($urandom());
		d.neg_child  = bspq_pkg::CHILD_BITS'($urandom());
		d.pos_vertex = bspq_pkg::VERT_BITS'($urandom());
		d.neg_vertex = bspq_pkg::VERT_BITS'($urandom());
		d.dir_x      = pick_comp();
		d.dir_y      = pick_comp();
		d.dir_z      = pick_comp();
		return d;
	endfunction

	// Random order of slots with the root kept at position zero.
	function automatic void shuffle_slots();
		int j;
		int t;
		for (int i = 0; i < bspq_pkg::NODE_COUNT; i++)
			slot_map[i] = i;
		for (int i = bspq_pkg::NODE_COUNT - 1; i > 1; i--) begin
			j = $urandom_range(i, 1);
			t = slot_map[i];
			slot_map[i] = slot_map[j];
			slot_map[j] = t;
		end
	endfunction

	function automatic int sender_idle_pct();
		if (rushing)
			return 0;
		case (pace)
			LAZY_SENDER: return 86;
			BOTH_SLOW:   return 18;
			default:     return 0;
		endcase
	endfunction

	function automatic int sink_stall_pct();
		case (pace)
			SLOW_SINK: return 86;
			BOTH_SLOW: return 18;
			default:   return 0;
		endcase
	endfunction

	// Present one request at a falling edge and hold it until it is taken.
	// Valid is only lowered when an idle gap actually follows.
	task automatic offer(input logic [0:0] act, input bspq_pkg::in_data_t d);
		int gap;
		int pct;
		gap = 0;
		pct = sender_idle_pct();
		while (gap < 200 && $urandom_range(99) < pct)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		s_tuser  <= act;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		tally.note_request(act, d);
		items_sent++;
		@(negedge clk);
	endtask

	// Issue a query, first loading any slot its descents would read unloaded.
	task automatic ask(input bspq_pkg::in_data_t q);
		int                 hole;
		bspq_pkg::in_data_t fill;
		hole = tally.first_hole(q);
		while (hole >= 0) begin
			fill = noise();
			fill.node_index = bspq_pkg::INDEX_BITS'(hole);
			offer(bspq_pkg::ACT_WRITE, fill);
			hole = tally.first_hole(q);
		end
		offer(bspq_pkg::ACT_QUERY, q);
	endtask

	task automatic ask_dir(input logic [bspq_pkg::COMP_BITS-1:0] dx,
			input logic [bspq_pkg::COMP_BITS-1:0] dy,
			input logic [bspq_pkg::COMP_BITS-1:0] dz);
		bspq_pkg::in_data_t q;
		q = noise();
		q.dir_x = dx;
		q.dir_y = dy;
		q.dir_z = dz;
		ask(q);
	endtask

	task automatic put_node(input int slot, input logic [bspq_pkg::COMP_BITS-1:0] nx,
			input logic [bspq_pkg::COMP_BITS-1:0] ny, input logic [bspq_pkg::COMP_BITS-1:0] nz,
			input logic [bspq_pkg::CHILD_BITS-1:0] pc, input logic [bspq_pkg::CHILD_BITS-1:0] nc,
			input logic [bspq_pkg::VERT_BITS-1:0] pv, input logic [bspq_pkg::VERT_BITS-1:0] nv);
		bspq_pkg::in_data_t d;
		d = noise();
		d.node_index = bspq_pkg::INDEX_BITS'(slot);
		d.normal_x   = nx;
		d.normal_y   = ny;
		d.normal_z   = nz;
		d.pos_child  = pc;
		d.neg_child  = nc;
		d.pos_vertex = pv;
		d.neg_vertex = nv;
		offer(bspq_pkg::ACT_WRITE, d);
	endtask

	// Load a well-formed tree in heap layout over random slots, rooted at slot 0.
	task automatic grow_heap(input int n);
		bspq_pkg::in_data_t d;
		shuffle_slots();
		for (int i = 0; i < n; i++) begin
			d = noise();
			d.node_index = bspq_pkg::INDEX_BITS'(slot_map[i]);
			d.pos_child = (2 * i + 1 < n) ? bspq_pkg::CHILD_BITS'(slot_map[2 * i + 1])
				: leaf_link();
			d.neg_child = (2 * i + 2 < n) ? bspq_pkg::CHILD_BITS'(slot_map[2 * i + 2])
				: leaf_link();
			offer(bspq_pkg::ACT_WRITE, d);
		end
	endtask

	// Load a deep chain; most nodes send both sides on to the next one.
	task automatic grow_chain(input int n);
		bspq_pkg::in_data_t              d;
		logic [bspq_pkg::CHILD_BITS-1:0] link;
		shuffle_slots();
		for (int i = 0; i < n; i++) begin
			d = noise();
			d.node_index = bspq_pkg::INDEX_BITS'(slot_map[i]);
			link = (i + 1 < n) ? bspq_pkg::CHILD_BITS'(slot_map[i + 1]) : leaf_link();
			d.pos_child = link;
			d.neg_child = link;
			if ($urandom_range(9) < 3) begin
				if ($urandom_range(1))
					d.pos_child = leaf_link();
				else
					d.neg_child = leaf_link();
			end
			offer(bspq_pkg::ACT_WRITE, d);
		end
	endtask

	// Result side: random stalls per pace, plus a counted hold-off when requested.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= sink_stall_pct());
			end
		end
	end

	// Take every accepted result into the scoreboard.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tally.check_result(m_tdata, m_tuser);
	end

	// Request stream: directed cases, a fill-up burst, then random trees and queries.
	initial begin
		int pick;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = bspq_pkg::ACT_WRITE;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Single leaf root: positive, zero and negative dot products.
		put_node(0, 16'h4000, 16'h0000, 16'h0000, 9'h1FF, 9'h100, 8'hA5, 8'h5A);
		ask_dir(16'h4000, 16'h0000, 16'h0000);
		ask_dir(16'h0000, 16'h0000, 16'h0000);
		ask_dir(16'h8000, 16'h8000, 16'h8000);

		// Three levels using the last slot and extreme normals.
		put_node(255, 16'h7FFF, 16'h7FFF, 16'h7FFF, 9'h1FF, 9'h1FF, 8'hFF, 8'h00);
		put_node(1, 16'h8000, 16'h8000, 16'h8000, 9'h0FF, 9'h1FF, 8'h01, 8'h80);
		put_node(0, 16'h0000, 16'h4000, 16'hC000, 9'h001, 9'h0FF, 8'h00, 8'h00);
		ask_dir(16'h7FFF, 16'h7FFF, 16'h7FFF);
		ask_dir(16'h8000, 16'h7FFF, 16'h8000);
		ask_dir(16'h0001, 16'hFFFF, 16'h0001);

		// Root pointing at itself on both sides: both walks run too long.
		put_node(0, 16'h0001, 16'h0001, 16'h0001, 9'h000, 9'h000, 8'h33, 8'h44);
		ask_dir(16'h0005, 16'h0005, 16'h0005);

		// Loop on one side only: one walk fails, the other still returns its vertex.
		put_node(0, 16'h0001, 16'h0000, 16'h0000, 9'h000, 9'h1FF, 8'h11, 8'h22);
		ask_dir(16'h0001, 16'h0000, 16'h0000);
		ask_dir(16'hFFFF, 16'h0000, 16'h0000);

		// Zero normal: every direction counts as positive.
		put_node(0, 16'h0000, 16'h0000, 16'h0000, 9'h1FF, 9'h1FF, 8'hC3, 8'h3C);
		ask_dir(16'h7FFF, 16'h8000, 16'h1234);

		// Hold results back while queries keep coming so the block backs up.
		rushing = 1'b1;
		hold_left = FILL_HOLD;
		repeat (16)
			ask(noise());
		rushing = 1'b0;

		while (items_sent < TOTAL_ITEMS) begin
			pace = pace_t'((items_sent * 8 / TOTAL_ITEMS) % 4);
			pick = $urandom_range(99);
			if (pick < 60) begin
				grow_heap(($urandom_range(99) < 85) ? $urandom_range(15, 2)
					: $urandom_range(63, 16));
				repeat ($urandom_range(10, 3))
					ask(noise());
			end else if (pick < 72) begin
				grow_chain($urandom_range(48, 4));
				repeat (3)
					ask(noise());
			end else if (pick < 88) begin
				repeat ($urandom_range(4, 1))
					offer(bspq_pkg::ACT_WRITE, noise());
			end else begin
				repeat ($urandom_range(3, 1))
					ask(noise());
			end
		end

		// Drain, then allow time for any spurious late result.
		s_tvalid <= 1'b0;
		while (tally.answers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tally.failures == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

	// Watchdog.
	initial begin
		#(200_000_000);
		$display("%0t ns: timeout with %0d results outstanding", $time, tally.answers.size());
		$display("testbench: errors");
		$finish;
	end

endmodule
